[design/mxp_pkg.sv]
package mxp_pkg;

    // feature map limits
    localparam int MAX_MAP_WIDTH  = 32;
    localparam int MAX_MAP_HEIGHT = 32;
    localparam int LINE_DEPTH     = MAX_MAP_WIDTH / 2;

    // field and counter widths
    localparam int SAMPLE_W = 16;
    localparam int DIM_W    = 6;
    localparam int COL_W    = $clog2(MAX_MAP_WIDTH);
    localparam int ROW_W    = $clog2(MAX_MAP_HEIGHT);
    localparam int LIDX_W   = $clog2(LINE_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = CFG_IDX_W'(1);
    localparam logic [DIM_W-1:0]     DIM_RESET      = DIM_W'(24);

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one pooling request: a horizontal pair maximum and where it goes
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pair_max;
        logic [LIDX_W-1:0]          line_idx;
        logic                       odd_row;
        logic                       last_in_map;
    } t_pool_req;

    // even, at least two, at most the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] e;
        e = {v[DIM_W-1:1], 1'b0};
        if (e < DIM_W'(2)) begin
            e = DIM_W'(2);
        end
        if (e > maxv) begin
            e = maxv;
        end
        return e;
    endfunction

endpackage

[design/max_pool_2x2_stride2_top.sv]
// o_valid rises after the odd-column sample of an odd row has passed the request
// queue and then the line store compare into the output register
// throughput: one sample per cycle while o_stall is low; a four-entry queue absorbs output stalls
// reset: synchronous, active low; map width and height return to 24, the
// raster position to the first sample; the line store is not cleared
module max_pool_2x2_stride2_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [mxp_pkg::SAMPLE_W-1:0]  i_sample_value,
    output logic                                 o_stall,
    output logic                                 o_valid,
    output logic signed [mxp_pkg::SAMPLE_W-1:0]  o_pooled_value,
    output logic                                 o_last_in_map,
    input  logic                                 i_stall,
    input  logic                                 i_cfg_we,
    input  logic [mxp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mxp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import mxp_pkg::*;

    logic      push;
    logic      full;
    logic      pop;
    logic      empty;
    t_pool_req front_req;
    t_pool_req back_req;

    // position tracking and pair maxima
    mxp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_sample_value (i_sample_value),
        .o_stall        (o_stall),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_push         (push),
        .o_req          (front_req),
        .i_full         (full)
    );

    // decoupling queue
    mxp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_req   (back_req)
    );

    // line store and window result
    mxp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_req          (back_req),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_pooled_value (o_pooled_value),
        .o_last_in_map  (o_last_in_map),
        .i_stall        (i_stall)
    );

endmodule

[design/mxp_front.sv]
module mxp_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [mxp_pkg::SAMPLE_W-1:0]  i_sample_value,
    output logic                                 o_stall,
    input  logic                                 i_cfg_we,
    input  logic [mxp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mxp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_push,
    output mxp_pkg::t_pool_req                   o_req,
    input  logic                                 i_full
);
    import mxp_pkg::*;

    localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_MAP_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_MAP_HEIGHT);

    logic [DIM_W-1:0]           r_width;
    logic [DIM_W-1:0]           r_height;
    logic [COL_W-1:0]           r_col;
    logic [ROW_W-1:0]           r_row;
    logic signed [SAMPLE_W-1:0] r_left;
    logic [COL_W-1:0]           n_col;
    logic [ROW_W-1:0]           n_row;
    logic                       acc;
    logic                       last_col;
    logic                       last_row;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;

    assign last_col = (DIM_W'(r_col) + DIM_W'(1)) == r_width;
    assign last_row = (DIM_W'(r_row) + DIM_W'(1)) == r_height;

    // odd column closes a pair: hand it to the back end
    assign o_push           = acc && r_col[0];
    assign o_req.pair_max   = (i_sample_value > r_left) ? i_sample_value : r_left;
    assign o_req.line_idx   = r_col[COL_W-1:1];
    assign o_req.odd_row    = r_row[0];
    assign o_req.last_in_map = last_col && last_row;

    // raster position advance
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // configuration and position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MAP_WIDTH) begin
                r_width <= clamp_dim(i_cfg_data, MAX_W);
            end else if (i_cfg_idx == REG_MAP_HEIGHT) begin
                r_height <= clamp_dim(i_cfg_data, MAX_H);
            end
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (acc && !r_col[0]) begin
                r_left <= i_sample_value;
            end
        end
    end

    // position stays inside the map
    a_col_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(r_col) < r_width)
        else $error("column position beyond map width");

    a_row_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(r_row) < r_height)
        else $error("row position beyond map height");

    // a map can only end on an odd row
    a_last_odd_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_req.last_in_map) |-> o_req.odd_row)
        else $error("end of map flagged on an even row");

endmodule

[design/mxp_queue.sv]
module mxp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mxp_pkg::t_pool_req i_req,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output mxp_pkg::t_pool_req o_req
);
    import mxp_pkg::*;

    t_pool_req         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_req   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // no request is dropped on a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("request pushed into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // pointers agree with the count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with unequal pointers");

endmodule

[design/mxp_back.sv]
module mxp_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  mxp_pkg::t_pool_req                   i_req,
    output logic                                 o_pop,
    output logic                                 o_valid,
    output logic signed [mxp_pkg::SAMPLE_W-1:0]  o_pooled_value,
    output logic                                 o_last_in_map,
    input  logic                                 i_stall
);
    import mxp_pkg::*;

    logic signed [SAMPLE_W-1:0] r_line [LINE_DEPTH];
    logic signed [SAMPLE_W-1:0] r_pooled;
    logic                       r_last;
    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] above;
    logic                       out_free;

    assign out_free = !r_valid || !i_stall;
    assign o_pop    = !i_empty && (!i_req.odd_row || out_free);
    assign above    = r_line[i_req.line_idx];

    // even-row pair maxima into the line store
    always_ff @(posedge i_clk) begin
        if (o_pop && !i_req.odd_row) begin
            r_line[i_req.line_idx] <= i_req.pair_max;
        end
    end

    // odd-row requests finish the window into the output register
    always_ff @(posedge i_clk) begin
        if (o_pop && i_req.odd_row) begin
            r_pooled <= (above > i_req.pair_max) ? above : i_req.pair_max;
            r_last   <= i_req.last_in_map;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && i_req.odd_row) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid        = r_valid;
    assign o_pooled_value = r_pooled;
    assign o_last_in_map  = r_last;

    // a window result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !(o_pop && i_req.odd_row))
        else $error("pending result overwritten");

    // line store writes never wait on the output side
    a_write_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_req.odd_row) |-> o_pop)
        else $error("line store write held back");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");

endmodule
